@@ rtl/pwl_pkg.sv @@
// Shared types, constants and codes of the piecewise linear lookup unit.
package pwl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DEF_MAX_POINTS = 256;
	localparam int DEF_NUM_CURVES = 3;

	localparam int PIX_W = 16 + FRAC_BITS;
	localparam int DIFF_W = ((PIX_W > 32) ? PIX_W : 32) + 2;
	localparam int MAG_W = 33;
	localparam int NUM_W = 2 * MAG_W;
	localparam int DEN_W = MAG_W;
	localparam int MUL_STEPS = MAG_W;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic CFG_OFFSET_X = 1'b0;
	localparam logic CFG_SCALE_X = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] chart_id;
		logic [7:0] point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic is_last;
		logic [15:0] pixel_x;
	} req_t;

	typedef struct packed {
		logic [1:0] chart_id_out;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic in_range;
	} res_t;

	typedef enum logic [1:0] {RD_ZERO, RD_LAST, RD_IDX, RD_IDXM1} rd_sel_t;
	typedef enum logic {DIV_MAP, DIV_INTERP} div_sel_t;
	typedef enum logic [1:0] {OUT_ZERO, OUT_RDY, OUT_LEFT, OUT_INTERP} out_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_MAP, ST_X0, ST_XL, ST_RD, ST_CMP,
		ST_RDP, ST_LEFT, ST_PREP, ST_MUL, ST_DIV
	} state_t;

	typedef struct packed {
		logic cap;
		logic load_wr;
		logic clear;
		logic rd_en;
		rd_sel_t rd_sel;
		logic take_cx;
		logic i_init;
		logic i_inc;
		logic take_right;
		logic take_left;
		logic mul_start;
		logic div_start;
		div_sel_t div_sel;
		logic fire;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic curve_ok;
		logic single;
		logic below;
		logic above;
		logic more;
		logic dx_zero;
		logic mul_done;
		logic div_done;
	} sts_t;

endpackage

@@ rtl/pwl_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pwl_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [pwl_pkg::NUM_W-1:0] num,
	input logic [pwl_pkg::DEN_W-1:0] den,
	output logic [pwl_pkg::NUM_W-1:0] quo,
	output logic done
);
	import pwl_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] sub;
	logic ge;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		sub = trial - {1'b0, den_q};
		ge = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quo = quo_q;
	assign done = done_q;

endmodule

@@ rtl/pwl_dp.sv @@
// Datapath: point stores, curve counts, config registers, multiplier, divider and result register.
module pwl_dp #(
	parameter int MAX_POINTS = pwl_pkg::DEF_MAX_POINTS,
	parameter int NUM_CURVES = pwl_pkg::DEF_NUM_CURVES
) (
	input logic clk,
	input logic arst_n,
	input pwl_pkg::req_t req,
	input logic cfg_valid,
	input logic cfg_index,
	input logic [31:0] cfg_data,
	input pwl_pkg::cmd_t cmd,
	output pwl_pkg::sts_t sts,
	output pwl_pkg::res_t result,
	output logic done
);
	import pwl_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int DEPTH = NUM_CURVES * MAX_POINTS;
	localparam int AW = $clog2(DEPTH);
	localparam int MC_W = $clog2(MUL_STEPS + 1);

	logic signed [31:0] offset_q;
	logic [23:0] scale_q;
	logic [CW-1:0] count_q [NUM_CURVES];
	logic [31:0] x_mem [DEPTH];
	logic [31:0] y_mem [DEPTH];
	logic signed [31:0] rdx_q, rdy_q;
	logic [1:0] cid_q;
	logic [15:0] pix_q;
	logic [CW-1:0] i_q;
	logic signed [31:0] cx_q, x0_q, y0_q, x1_q, y1_q;
	logic [NUM_W-1:0] mcand_q, prod_q;
	logic [MAG_W-1:0] mplier_q;
	logic [MC_W-1:0] mcnt_q;
	logic mrun_q, mdone_q;
	res_t res_q;
	logic done_q;

	logic [CW-1:0] n;
	logic wr_ok;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW-1:0] rd_local;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] dmag;
	logic [NUM_W-1:0] div_num, quo;
	logic [DEN_W-1:0] div_den;
	logic div_done;
	logic signed [31:0] cx_next;
	logic signed [MAG_W-1:0] dx, dy, tt;
	logic [MAG_W-1:0] dx_m, dy_m, t_m;
	logic [MAG_W:0] qc;
	logic signed [MAG_W+2:0] isum;
	logic signed [31:0] iy;

	always_comb begin
		n = '0;
		for (int c = 0; c < NUM_CURVES; c++) begin
			if (int'(cid_q) == c) begin
				n = count_q[c];
			end
		end
	end

	always_comb begin
		wr_ok = cmd.load_wr && (int'(req.chart_id) < NUM_CURVES)
			&& (int'(req.point_index) < MAX_POINTS);
		wr_addr = AW'(req.chart_id) * AW'(MAX_POINTS) + AW'(req.point_index);
		case (cmd.rd_sel)
			RD_ZERO: rd_local = '0;
			RD_LAST: rd_local = n - 1'b1;
			RD_IDX: rd_local = i_q;
			RD_IDXM1: rd_local = i_q - 1'b1;
			default: rd_local = '0;
		endcase
		rd_addr = AW'(cid_q) * AW'(MAX_POINTS) + AW'(rd_local);
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			x_mem[wr_addr] <= req.point_x;
			y_mem[wr_addr] <= req.point_y;
		end
		if (cmd.rd_en) begin
			rdx_q <= x_mem[rd_addr];
			rdy_q <= y_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			scale_q <= 24'(1 << FRAC_BITS);
			for (int c = 0; c < NUM_CURVES; c++) begin
				count_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_OFFSET_X: offset_q <= cfg_data;
					CFG_SCALE_X: scale_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			for (int c = 0; c < NUM_CURVES; c++) begin
				if (int'(req.chart_id) == c) begin
					if (wr_ok && req.is_last) begin
						count_q[c] <= CW'(req.point_index) + 1'b1;
					end
					if (cmd.clear) begin
						count_q[c] <= '0;
					end
				end
			end
		end
	end

	always_comb begin
		diff = $signed({2'b00, pix_q, {FRAC_BITS{1'b0}}}) - DIFF_W'(offset_q);
		dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		dx = {x1_q[31], x1_q} - {x0_q[31], x0_q};
		dy = {y1_q[31], y1_q} - {y0_q[31], y0_q};
		tt = {cx_q[31], cx_q} - {x0_q[31], x0_q};
		dx_m = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		dy_m = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
		t_m = tt[MAG_W-1] ? MAG_W'(-tt) : MAG_W'(tt);
		if (cmd.div_sel == DIV_MAP) begin
			div_num = NUM_W'({dmag, {FRAC_BITS{1'b0}}});
			div_den = DEN_W'((scale_q == '0) ? 24'd1 : scale_q);
		end else begin
			div_num = prod_q;
			div_den = dx_m;
		end
	end

	pwl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(div_den),
		.quo(quo),
		.done(div_done)
	);

	always_comb begin
		if (!diff[DIFF_W-1]) begin
			cx_next = (|quo[NUM_W-1:31]) ? 32'sh7fff_ffff : $signed(quo[31:0]);
		end else if ((|quo[NUM_W-1:32]) || (quo[31] && (|quo[30:0]))) begin
			cx_next = 32'sh8000_0000;
		end else begin
			cx_next = $signed(-quo[31:0]);
		end
		if ((|quo[NUM_W-1:MAG_W+1]) || (quo[MAG_W] && (|quo[MAG_W-1:0]))) begin
			qc = {1'b1, {MAG_W{1'b0}}};
		end else begin
			qc = quo[MAG_W:0];
		end
		if (dx[MAG_W-1] ^ dy[MAG_W-1] ^ tt[MAG_W-1]) begin
			isum = (MAG_W+3)'(y0_q) - $signed({2'b00, qc});
		end else begin
			isum = (MAG_W+3)'(y0_q) + $signed({2'b00, qc});
		end
		if (isum > 36'sh0_7fff_ffff) begin
			iy = 32'sh7fff_ffff;
		end else if (isum < -36'sh0_8000_0000) begin
			iy = 32'sh8000_0000;
		end else begin
			iy = isum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			done_q <= cmd.fire;
			if (cmd.mul_start) begin
				mrun_q <= 1'b1;
				mcnt_q <= MC_W'(MUL_STEPS);
			end else if (mrun_q) begin
				mcnt_q <= mcnt_q - 1'b1;
				if (mcnt_q == MC_W'(1)) begin
					mrun_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cid_q <= req.chart_id;
			pix_q <= req.pixel_x;
		end
		if (cmd.take_cx) begin
			cx_q <= cx_next;
		end
		if (cmd.i_init) begin
			i_q <= CW'(1);
		end else if (cmd.i_inc) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.take_right) begin
			x1_q <= rdx_q;
			y1_q <= rdy_q;
		end
		if (cmd.take_left) begin
			x0_q <= rdx_q;
			y0_q <= rdy_q;
		end
		if (cmd.mul_start) begin
			mcand_q <= NUM_W'(dy_m);
			mplier_q <= t_m;
			prod_q <= '0;
		end else if (mrun_q) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= {mcand_q[NUM_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MAG_W-1:1]};
		end
		if (cmd.fire) begin
			res_q.chart_id_out <= cid_q;
			case (cmd.out_sel)
				OUT_ZERO: begin
					res_q.value_x <= '0;
					res_q.value_y <= '0;
					res_q.in_range <= 1'b0;
				end
				OUT_RDY: begin
					res_q.value_x <= cx_q;
					res_q.value_y <= rdy_q;
					res_q.in_range <= 1'b1;
				end
				OUT_LEFT: begin
					res_q.value_x <= cx_q;
					res_q.value_y <= y0_q;
					res_q.in_range <= 1'b1;
				end
				OUT_INTERP: begin
					res_q.value_x <= cx_q;
					res_q.value_y <= iy;
					res_q.in_range <= 1'b1;
				end
				default: begin
					res_q.value_x <= '0;
					res_q.value_y <= '0;
					res_q.in_range <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		sts.curve_ok = (int'(cid_q) < NUM_CURVES) && (n != '0);
		sts.single = n == CW'(1);
		sts.below = cx_q < rdx_q;
		sts.above = cx_q > rdx_q;
		sts.more = (i_q < n - 1'b1) && (cx_q > rdx_q);
		sts.dx_zero = dx == '0;
		sts.mul_done = mdone_q;
		sts.div_done = div_done;
	end

	assign result = res_q;
	assign done = done_q;

endmodule

@@ rtl/pwl_ctrl.sv @@
// Controller state machine sequencing loads, clears and queries.
module pwl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] req_type,
	input pwl_pkg::sts_t sts,
	output pwl_pkg::cmd_t cmd,
	output logic busy
);
	import pwl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = RD_ZERO;
		cmd.div_sel = DIV_MAP;
		cmd.out_sel = OUT_ZERO;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					cmd.load_wr = req_type == REQ_LOAD;
					cmd.clear = req_type == REQ_CLEAR;
					if (req_type == REQ_QUERY) begin
						state_d = ST_CHK;
					end
				end
			end
			ST_CHK: begin
				if (!sts.curve_ok) begin
					cmd.fire = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				if (sts.div_done) begin
					cmd.take_cx = 1'b1;
					cmd.rd_en = 1'b1;
					state_d = ST_X0;
				end
			end
			ST_X0: begin
				if (sts.below) begin
					cmd.fire = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_LAST;
					state_d = ST_XL;
				end
			end
			ST_XL: begin
				if (sts.above) begin
					cmd.fire = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.single) begin
					cmd.fire = 1'b1;
					cmd.out_sel = OUT_RDY;
					state_d = ST_IDLE;
				end else begin
					cmd.i_init = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.more) begin
					cmd.i_inc = 1'b1;
					state_d = ST_RD;
				end else begin
					cmd.take_right = 1'b1;
					state_d = ST_RDP;
				end
			end
			ST_RDP: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_IDXM1;
				state_d = ST_LEFT;
			end
			ST_LEFT: begin
				cmd.take_left = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				if (sts.dx_zero) begin
					cmd.fire = 1'b1;
					cmd.out_sel = OUT_LEFT;
					state_d = ST_IDLE;
				end else begin
					cmd.mul_start = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.div_sel = DIV_INTERP;
				if (sts.mul_done) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_sel = DIV_INTERP;
				if (sts.div_done) begin
					cmd.fire = 1'b1;
					cmd.out_sel = OUT_INTERP;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

@@ rtl/piecewise_linear_lookup_unit.sv @@
// Piecewise linear lookup unit: top level joining controller and datapath.
// Load, clear and no-op items are taken in the idle state and give no result; busy stays low.
// A query runs a linear search of up to MAX_POINTS - 2 steps and uses the bit-serial divider
// to map the pixel and, when it interpolates, again after the bit-serial multiplier.
// Queries on an empty or unknown curve answer with a zero result. One query at a time; no stall.
// Reset clears curve counts and offset and sets scale to 1.0; point stores are not cleared.
module piecewise_linear_lookup_unit #(
	parameter int MAX_POINTS = pwl_pkg::DEF_MAX_POINTS,
	parameter int NUM_CURVES = pwl_pkg::DEF_NUM_CURVES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input pwl_pkg::req_t req,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data,
	output pwl_pkg::res_t result,
	output logic done
);
	import pwl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pwl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req.req_type),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	pwl_dp #(
		.MAX_POINTS(MAX_POINTS),
		.NUM_CURVES(NUM_CURVES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.result(result),
		.done(done)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.in_range |-> result.value_x == 0 && result.value_y == 0)
		else $error("out of range result not zero");
	a_busy_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req.req_type == REQ_QUERY))
		else $error("busy without query item");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the piecewise linear lookup unit: directed and random items checked by a predictor.
module tb;
	import pwl_pkg::*;

	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam logic [1:0] BAD_CURVE = 2'd3;
	localparam int CURVES = DEF_NUM_CURVES;
	localparam int POINTS = DEF_MAX_POINTS;
	localparam longint ONE_FX = longint'(1) << FRAC_BITS;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint unsigned LIM32 = 64'd1 << 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_OFFSET_X;
	logic [31:0] cfg_data = '0;
	res_t result;
	logic done;

	logic signed [31:0] curve_x [CURVES][POINTS];
	logic signed [31:0] curve_y [CURVES][POINTS];
	int unsigned curve_len [CURVES] = '{default: 0};
	bit point_set [CURVES][POINTS] = '{default: '{default: 1'b0}};
	logic signed [31:0] offset_reg = '0;
	logic [23:0] scale_reg = 24'(ONE_FX);

	req_t pending_items[$];
	res_t expected_answers[$];
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int err_cnt = 0;
	int gap_max = 0;
	int gap_left = 0;

	piecewise_linear_lookup_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result(result),
		.done(done)
	);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > I32_MAX) return 32'sh7fffffff;
		if (v < I32_MIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned mag(input longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic logic signed [31:0] curve_x_of(input logic [15:0] pix);
		longint diff;
		longint unsigned d, m, q, r, v;
		diff = (longint'(pix) <<< FRAC_BITS) - longint'(offset_reg);
		d = (scale_reg == 0) ? 64'd1 : 64'(scale_reg);
		m = mag(diff);
		q = m / d;
		r = m % d;
		if (q >= LIM32) v = LIM32;
		else v = (q << FRAC_BITS) + ((r << FRAC_BITS) / d);
		if (v > LIM32) v = LIM32;
		return sat32((diff < 0) ? -longint'(v) : longint'(v));
	endfunction

	function automatic logic signed [31:0] interp_y(input logic signed [31:0] x0, y0, x1, y1, x);
		longint dx, dy, t;
		logic [65:0] quot;
		bit neg;
		dx = longint'(x1) - longint'(x0);
		dy = longint'(y1) - longint'(y0);
		t = longint'(x) - longint'(x0);
		if (dx == 0) return y0;
		quot = (66'(mag(dy)) * 66'(mag(t))) / 66'(mag(dx));
		if (quot > (66'd1 << 33)) quot = 66'd1 << 33;
		neg = ((dy < 0) != (t < 0)) != (dx < 0);
		if (dy == 0 || t == 0) neg = 1'b0;
		return sat32(longint'(y0) + (neg ? -longint'(quot[63:0]) : longint'(quot[63:0])));
	endfunction

	function automatic void apply_item(input req_t r);
		res_t a;
		logic signed [31:0] cx;
		int unsigned n, i;
		case (r.req_type)
			REQ_LOAD: begin
				if (r.chart_id < CURVES) begin
					curve_x[r.chart_id][r.point_index] = r.point_x;
					curve_y[r.chart_id][r.point_index] = r.point_y;
					if (r.is_last) curve_len[r.chart_id] = r.point_index + 1;
				end
			end
			REQ_CLEAR: begin
				if (r.chart_id < CURVES) curve_len[r.chart_id] = 0;
			end
			REQ_QUERY: begin
				a = '0;
				a.chart_id_out = r.chart_id;
				if (r.chart_id < CURVES && curve_len[r.chart_id] != 0) begin
					n = curve_len[r.chart_id];
					cx = curve_x_of(r.pixel_x);
					if (!(cx < curve_x[r.chart_id][0] || cx > curve_x[r.chart_id][n - 1])) begin
						a.in_range = 1'b1;
						a.value_x = cx;
						if (n == 1) begin
							a.value_y = curve_y[r.chart_id][0];
						end else begin
							i = 1;
							while (i < n - 1 && cx > curve_x[r.chart_id][i]) i++;
							a.value_y = interp_y(curve_x[r.chart_id][i - 1],
								curve_y[r.chart_id][i - 1], curve_x[r.chart_id][i],
								curve_y[r.chart_id][i], cx);
						end
					end
				end
				expected_answers.push_back(a);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit free;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			free = !start || !busy;
			if (start && !busy) begin
				apply_item(req);
				accepted_cnt++;
				gap_left = $urandom_range(0, gap_max);
			end
			if (free) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req <= pending_items.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				err_cnt++;
				$display("%0t: result with none expected, actual %p", $time, result);
			end else begin
				want = expected_answers.pop_front();
				if (result.chart_id_out !== want.chart_id_out) begin
					err_cnt++;
					$display("%0t: chart_id_out expected %0d actual %0d", $time,
						want.chart_id_out, result.chart_id_out);
				end
				if (result.value_x !== want.value_x) begin
					err_cnt++;
					$display("%0t: value_x expected %0d actual %0d", $time,
						want.value_x, result.value_x);
				end
				if (result.value_y !== want.value_y) begin
					err_cnt++;
					$display("%0t: value_y expected %0d actual %0d", $time,
						want.value_y, result.value_y);
				end
				if (result.in_range !== want.in_range) begin
					err_cnt++;
					$display("%0t: in_range expected %0b actual %0b", $time,
						want.in_range, result.in_range);
				end
			end
		end
	end

	function automatic req_t make_item(input logic [1:0] kind, input logic [1:0] cid,
		input logic [7:0] idx, input logic signed [31:0] x, input logic signed [31:0] y,
		input logic last, input logic [15:0] pix);
		req_t r;
		r.req_type = kind;
		r.chart_id = cid;
		r.point_index = idx;
		r.point_x = x;
		r.point_y = y;
		r.is_last = last;
		r.pixel_x = pix;
		return r;
	endfunction

	task automatic send(input req_t r);
		bit whole;
		if (r.req_type == REQ_LOAD && r.chart_id < CURVES) begin
			point_set[r.chart_id][r.point_index] = 1'b1;
			whole = 1'b1;
			for (int i = 0; i <= r.point_index; i++) whole &= point_set[r.chart_id][i];
			if (!whole) r.is_last = 1'b0;
		end
		pending_items.push_back(r);
		queued_cnt++;
	endtask

	task automatic send_query(input logic [1:0] cid, input logic [15:0] pix);
		send(make_item(REQ_QUERY, cid, 8'($urandom), 32'($urandom), 32'($urandom),
			1'($urandom), pix));
	endtask

	task automatic send_noise();
		send(make_item(2'($urandom), 2'($urandom), 8'($urandom), 32'($urandom),
			32'($urandom), 1'($urandom), 16'($urandom)));
	endtask

	task automatic send_curve(input logic [1:0] cid, input int n, input int queries);
		int p, first, lo, hi;
		logic signed [31:0] x;
		first = $urandom_range(0, 30000);
		p = first;
		for (int i = 0; i < n; i++) begin
			x = curve_x_of(16'(p));
			if ($urandom_range(0, 19) == 0) x = x + $signed(32'($urandom_range(0, 6))) - 3;
			send(make_item(REQ_LOAD, cid, 8'(i), x, 32'($urandom), i == n - 1, 16'($urandom)));
			if (i < n - 1) p = (p + $urandom_range(0, 40) > 65535) ? 65535 : p + $urandom_range(0, 40);
		end
		lo = (first > 2) ? first - 2 : 0;
		hi = (p < 65533) ? p + 2 : 65535;
		for (int i = 0; i < queries; i++) begin
			if ($urandom_range(0, 9) == 0) send_query(cid, 16'($urandom));
			else send_query(cid, 16'($urandom_range(lo, hi)));
		end
	endtask

	task automatic settle();
		do @(posedge clk); while (accepted_cnt != queued_cnt || expected_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_OFFSET_X) offset_reg = val;
		else scale_reg = val[23:0];
	endtask

	task automatic run_phase(input logic [31:0] offs, input logic [23:0] scl, input int items,
		input int idle);
		int unsigned base;
		write_reg(CFG_OFFSET_X, offs);
		write_reg(CFG_SCALE_X, 32'(scl));
		gap_max = idle;
		base = queued_cnt;
		while (queued_cnt - base < items) begin
			if ($urandom_range(0, 4) == 0) send_noise();
			else send_curve(2'($urandom_range(0, CURVES - 1)), $urandom_range(1, 8),
				$urandom_range(1, 5));
		end
		settle();
	endtask

	initial begin
		logic signed [31:0] xa, xb;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_OFFSET_X, 32'd0);
		write_reg(CFG_SCALE_X, 32'(ONE_FX));
		gap_max = 3;

		send_query(2'd0, 16'd0);
		send_query(BAD_CURVE, 16'hffff);
		send(make_item(REQ_NOP, 2'd1, 8'hff, 32'hffffffff, 32'hffffffff, 1'b1, 16'hffff));
		send(make_item(REQ_LOAD, BAD_CURVE, 8'd0, 32'd0, 32'd0, 1'b1, 16'd0));
		send(make_item(REQ_CLEAR, BAD_CURVE, 8'd0, 32'd0, 32'd0, 1'b0, 16'd0));
		send(make_item(REQ_LOAD, 2'd1, 8'd0, curve_x_of(16'd100), 32'sh80000000, 1'b1, 16'd0));
		send_query(2'd1, 16'd100);
		send_query(2'd1, 16'd101);
		send_query(2'd1, 16'd99);
		xa = curve_x_of(16'd10);
		xb = curve_x_of(16'd50);
		send(make_item(REQ_LOAD, 2'd0, 8'd0, xa, 32'sh7fffffff, 1'b0, 16'd0));
		send(make_item(REQ_LOAD, 2'd0, 8'd1, xa, 32'sh80000000, 1'b0, 16'd0));
		send(make_item(REQ_LOAD, 2'd0, 8'd2, xb, 32'sh7fffffff, 1'b1, 16'd0));
		send_query(2'd0, 16'd10);
		send_query(2'd0, 16'd30);
		send_query(2'd0, 16'd50);
		send(make_item(REQ_LOAD, 2'd2, 8'd0, curve_x_of(16'd40), 32'sh80000000, 1'b0, 16'd0));
		send(make_item(REQ_LOAD, 2'd2, 8'd1, curve_x_of(16'd20), 32'sh7fffffff, 1'b0, 16'd0));
		send(make_item(REQ_LOAD, 2'd2, 8'd2, curve_x_of(16'd60), 32'sh80000000, 1'b0, 16'd0));
		send(make_item(REQ_LOAD, 2'd2, 8'd3, curve_x_of(16'd30), 32'sh00010000, 1'b1, 16'd0));
		send_query(2'd2, 16'd30);
		send_query(2'd2, 16'd45);
		send_query(2'd2, 16'd60);
		send(make_item(REQ_LOAD, 2'd0, 8'd255, 32'sh7fffffff, 32'sh80000000, 1'b0, 16'd0));
		send(make_item(REQ_CLEAR, 2'd0, 8'd0, 32'd0, 32'd0, 1'b0, 16'd0));
		send_query(2'd0, 16'd30);
		settle();

		run_phase(32'd0, 24'(ONE_FX), 20, 3);
		run_phase(32'h80000000, 24'd6554, 20, 0);
		run_phase(32'h7fffffff, 24'hffffff, 20, 3);
		run_phase(32'd0, 24'd0, 15, 1);
		for (int k = 0; k < 4; k++)
			run_phase(32'($urandom), 24'($urandom_range(6554, 24'hffffff)), 20, k % 2 ? 0 : 3);
		write_reg(CFG_OFFSET_X, 32'h00100000);
		write_reg(CFG_SCALE_X, 32'(ONE_FX));
		gap_max = 1;
		send_curve(2'd1, POINTS, 6);
		settle();

		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
